>>> hdl/jst_pkg.sv
// Shared types, constants and character helpers for the JSON stream tokenizer.
`default_nettype none
package jst_pkg;

  localparam int MAX_DEPTH = 32;
  localparam int STK_AW    = $clog2(MAX_DEPTH);
  localparam int LVL_W     = 6;
  localparam int OQ_DEPTH  = 4;
  localparam int OQ_AW     = $clog2(OQ_DEPTH);

  // event codes
  localparam logic [3:0] EV_OBJ_OPEN  = 4'd0;
  localparam logic [3:0] EV_ARR_OPEN  = 4'd1;
  localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
  localparam logic [3:0] EV_ARR_CLOSE = 4'd3;
  localparam logic [3:0] EV_NAME_CHAR = 4'd4;
  localparam logic [3:0] EV_NAME_END  = 4'd5;
  localparam logic [3:0] EV_STR_CHAR  = 4'd6;
  localparam logic [3:0] EV_STR_END   = 4'd7;
  localparam logic [3:0] EV_PRIM_CHAR = 4'd8;
  localparam logic [3:0] EV_PRIM_END  = 4'd9;
  localparam logic [3:0] EV_TEXT_END  = 4'd10;
  localparam logic [3:0] EV_ERROR     = 4'd11;

  // error codes
  localparam logic [3:0] ER_SYNTAX   = 4'd0;
  localparam logic [3:0] ER_BADCHAR  = 4'd1;
  localparam logic [3:0] ER_OBJ      = 4'd2;
  localparam logic [3:0] ER_ARR      = 4'd3;
  localparam logic [3:0] ER_OBJ_END  = 4'd4;
  localparam logic [3:0] ER_ARR_END  = 4'd5;
  localparam logic [3:0] ER_STRING   = 4'd6;
  localparam logic [3:0] ER_COMMA    = 4'd7;
  localparam logic [3:0] ER_EOF      = 4'd8;
  localparam logic [3:0] ER_NEWLINE  = 4'd9;
  localparam logic [3:0] ER_UNTERM   = 4'd10;
  localparam logic [3:0] ER_DEPTH    = 4'd11;

  // primitive kinds
  localparam logic [1:0] PK_TRUE  = 2'd0;
  localparam logic [1:0] PK_FALSE = 2'd1;
  localparam logic [1:0] PK_NULL  = 2'd2;
  localparam logic [1:0] PK_NUM   = 2'd3;

  // literal matcher states
  localparam logic [3:0] LM_NONE   = 4'd0;
  localparam logic [3:0] LM_NUM    = 4'd1;
  localparam logic [3:0] LM_T      = 4'd2;
  localparam logic [3:0] LM_TRUE   = 4'd5;
  localparam logic [3:0] LM_F      = 4'd6;
  localparam logic [3:0] LM_FALSE  = 4'd10;
  localparam logic [3:0] LM_N      = 4'd11;
  localparam logic [3:0] LM_NULL   = 4'd14;

  // characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [9:0] {
    M_START  = 10'b0000000001,
    M_ITEM   = 10'b0000000010,
    M_NEED   = 10'b0000000100,
    M_NAME   = 10'b0000001000,
    M_COLON  = 10'b0000010000,
    M_VALUE  = 10'b0000100000,
    M_STR    = 10'b0001000000,
    M_PRIM   = 10'b0010000000,
    M_SEP    = 10'b0100000000,
    M_CLOSED = 10'b1000000000
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [LVL_W-1:0] lvl;
    logic [3:0]       lit;
    logic             dec;
    logic             err;
    logic             top_obj;
  } pstate_t;

  typedef struct packed {
    logic [3:0]       ev;
    logic [7:0]       data;
    logic [LVL_W-1:0] depth;
    logic [1:0]       kind;
    logic [3:0]       errc;
    logic             last;
  } res_t;

  typedef struct packed {
    logic en;
    logic obj;
  } stk_wr_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic prim_start(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           is_digit(c) || (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  // expected next letter of true/false/null, zero where none
  function automatic logic [7:0] lit_next(input logic [3:0] m);
    logic [7:0] r;
    unique case (m)
      4'd2:    r = 8'h72;
      4'd3:    r = 8'h75;
      4'd4:    r = 8'h65;
      4'd6:    r = 8'h61;
      4'd7:    r = 8'h6C;
      4'd8:    r = 8'h73;
      4'd9:    r = 8'h65;
      4'd11:   r = 8'h75;
      4'd12:   r = 8'h6C;
      4'd13:   r = 8'h6C;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/jst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module jst_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/jst_step.sv
// Per-byte parse step: next state, stack write and up to two token events.
`default_nettype none
module jst_step (
  input  wire  jst_pkg::pstate_t            st,
  input  wire  logic [7:0]                  c,
  input  wire  logic [5:0]                  depth_limit,
  input  wire  logic                        below_obj,
  output jst_pkg::pstate_t                  st_next,
  output jst_pkg::stk_wr_t                  stk_wr,
  output jst_pkg::res_t                     res0,
  output jst_pkg::res_t                     res1,
  output logic [1:0]                        nres
);
  import jst_pkg::*;

  function automatic res_t mk(input logic [3:0] ev, input logic [7:0] d,
                              input logic [LVL_W-1:0] dp, input logic [1:0] k,
                              input logic [3:0] e);
    res_t r;
    r.ev = ev; r.data = d; r.depth = dp; r.kind = k; r.errc = e; r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    pstate_t          nx;
    res_t             rr [2];
    logic [1:0]       n;
    logic [LVL_W-1:0] lim;
    logic             obj;
    logic             ws;
    logic             do_item, do_start, do_value;
    logic             do_open, do_close, do_begin;
    logic             do_fail;
    logic [3:0]       fcode;
    logic [3:0]       m;

    nx = st;
    rr[0] = mk(EV_TEXT_END, 8'd0, '0, 2'd0, 4'd0);
    rr[1] = rr[0];
    n = 2'd0;
    lim = (depth_limit < LVL_W'(MAX_DEPTH)) ? depth_limit : LVL_W'(MAX_DEPTH);
    obj = (st.lvl != '0) && st.top_obj;
    ws = is_ws(c);
    do_item = 1'b0; do_start = 1'b0; do_value = 1'b0;
    do_open = 1'b0; do_close = 1'b0; do_begin = 1'b0;
    do_fail = 1'b0; fcode = ER_SYNTAX;
    m = st.lit;
    stk_wr.en = 1'b0;
    stk_wr.obj = (c == CH_LBRACE);

    if (c == CH_NUL) begin
      // end of text: report dangling token, then clear parse state
      if (!st.err) begin
        unique case (st.mode)
          M_NAME, M_STR: begin
            rr[n[0]] = mk(EV_ERROR, 8'd0, st.lvl, 2'd0, ER_UNTERM); n = n + 2'd1;
          end
          M_COLON, M_VALUE, M_SEP, M_NEED, M_PRIM: begin
            rr[n[0]] = mk(EV_ERROR, 8'd0, st.lvl, 2'd0, ER_EOF); n = n + 2'd1;
          end
          default: ;
        endcase
      end
      rr[n[0]] = mk(EV_TEXT_END, 8'd0, st.lvl, 2'd0, 4'd0); n = n + 2'd1;
      nx.mode = M_START; nx.lvl = '0; nx.lit = LM_NONE; nx.dec = 1'b0;
      nx.err = 1'b0;
    end else if (!st.err) begin
      // mode dispatch
      unique case (st.mode)
        M_START: do_start = !ws;
        M_ITEM, M_NEED: do_item = !ws;
        M_NAME: begin
          if (c == CH_QUOTE) begin
            rr[n[0]] = mk(EV_NAME_END, 8'd0, st.lvl, 2'd0, 4'd0); n = n + 2'd1;
            nx.mode = M_COLON;
          end else if (c == CH_LF) begin
            do_fail = 1'b1; fcode = ER_NEWLINE;
          end else begin
            rr[n[0]] = mk(EV_NAME_CHAR, c, st.lvl, 2'd0, 4'd0); n = n + 2'd1;
          end
        end
        M_COLON: begin
          if (c == CH_COLON) nx.mode = M_VALUE;
          else if (!ws) do_fail = 1'b1;
        end
        M_VALUE: do_value = !ws;
        M_STR: begin
          if (c == CH_QUOTE) begin
            rr[n[0]] = mk(EV_STR_END, 8'd0, st.lvl, 2'd0, 4'd0); n = n + 2'd1;
            nx.mode = M_SEP;
          end else if (c == CH_LF) begin
            do_fail = 1'b1; fcode = ER_NEWLINE;
          end else begin
            rr[n[0]] = mk(EV_STR_CHAR, c, st.lvl, 2'd0, 4'd0); n = n + 2'd1;
          end
        end
        M_PRIM: begin
          if (!(ws || c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE)) begin
            // extend primitive
            if (m == LM_NUM) begin
              if (c == CH_POINT) begin
                if (st.dec) m = LM_NONE;
                else nx.dec = 1'b1;
              end else if (!is_digit(c)) begin
                m = LM_NONE;
              end
            end else if (m != LM_NONE && lit_next(m) != 8'd0 && lit_next(m) == c) begin
              m = m + 4'd1;
            end else begin
              m = LM_NONE;
            end
            nx.lit = m;
            rr[n[0]] = mk(EV_PRIM_CHAR, c, st.lvl, 2'd0, 4'd0); n = n + 2'd1;
          end else if (m == LM_NUM || m == LM_TRUE || m == LM_FALSE || m == LM_NULL) begin
            // primitive complete
            priority if (m == LM_NUM)
              rr[n[0]] = mk(EV_PRIM_END, 8'd0, st.lvl, PK_NUM, 4'd0);
            else if (m == LM_TRUE)
              rr[n[0]] = mk(EV_PRIM_END, 8'd0, st.lvl, PK_TRUE, 4'd0);
            else if (m == LM_FALSE)
              rr[n[0]] = mk(EV_PRIM_END, 8'd0, st.lvl, PK_FALSE, 4'd0);
            else
              rr[n[0]] = mk(EV_PRIM_END, 8'd0, st.lvl, PK_NULL, 4'd0);
            n = n + 2'd1;
            if (ws) nx.mode = M_SEP;
            else if (c == CH_COMMA) nx.mode = M_ITEM;
            else do_item = 1'b1;
          end else begin
            do_fail = 1'b1;
          end
        end
        M_SEP: begin
          if (!ws) begin
            if (c == CH_COMMA) nx.mode = M_ITEM;
            else if (obj || c == CH_RBRACK) do_item = 1'b1;
            else do_fail = 1'b1;
          end
        end
        M_CLOSED: begin
          if (!ws) begin
            if (st.lvl == '0) begin
              if (c == CH_COMMA) begin
                do_fail = 1'b1; fcode = ER_COMMA;
              end else begin
                do_start = 1'b1;
              end
            end else if (c == CH_COMMA) begin
              nx.mode = M_NEED;
            end else begin
              do_item = 1'b1;
            end
          end
        end
        default: do_fail = 1'b1;
      endcase

      // token starts
      if (do_start) begin
        if (st.lvl >= lim) begin
          do_fail = 1'b1; fcode = ER_DEPTH;
        end else if (c == CH_LBRACE || c == CH_LBRACK) begin
          do_open = 1'b1;
        end else if (c == CH_RBRACE || c == CH_RBRACK || c == CH_QUOTE || prim_start(c)) begin
          do_fail = 1'b1;
        end else begin
          do_fail = 1'b1; fcode = ER_BADCHAR;
        end
      end
      if (do_item) begin
        if (st.lvl >= lim) begin
          do_fail = 1'b1; fcode = ER_DEPTH;
        end else if (c == CH_LBRACE || c == CH_LBRACK) begin
          if (!obj) do_open = 1'b1;
          else begin
            do_fail = 1'b1; fcode = (c == CH_LBRACE) ? ER_OBJ : ER_ARR;
          end
        end else if (c == CH_RBRACE) begin
          if (obj) do_close = 1'b1;
          else begin
            do_fail = 1'b1; fcode = ER_OBJ_END;
          end
        end else if (c == CH_RBRACK) begin
          if (!obj) do_close = 1'b1;
          else begin
            do_fail = 1'b1; fcode = ER_ARR_END;
          end
        end else if (c == CH_QUOTE) begin
          nx.mode = obj ? M_NAME : M_STR;
        end else if (prim_start(c)) begin
          if (obj) begin
            do_fail = 1'b1; fcode = ER_STRING;
          end else begin
            do_begin = 1'b1;
          end
        end else begin
          do_fail = 1'b1; fcode = ER_BADCHAR;
        end
      end
      if (do_value) begin
        if (c == CH_LBRACE || c == CH_LBRACK) do_open = 1'b1;
        else if (c == CH_RBRACE) begin
          do_fail = 1'b1; fcode = ER_OBJ_END;
        end else if (c == CH_RBRACK) begin
          do_fail = 1'b1; fcode = ER_ARR_END;
        end else if (c == CH_QUOTE) nx.mode = M_STR;
        else if (prim_start(c)) do_begin = 1'b1;
        else do_fail = 1'b1;
      end

      // container push
      if (do_open) begin
        if (st.lvl >= LVL_W'(MAX_DEPTH)) begin
          do_fail = 1'b1; fcode = ER_DEPTH;
        end else begin
          stk_wr.en = 1'b1;
          nx.lvl = st.lvl + LVL_W'(1);
          nx.top_obj = (c == CH_LBRACE);
          nx.mode = M_ITEM;
          rr[n[0]] = mk((c == CH_LBRACE) ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'd0, nx.lvl,
                        2'd0, 4'd0);
          n = n + 2'd1;
        end
      end
      // container pop: the entry below the top comes from the RAM
      if (do_close) begin
        if (st.lvl != '0) nx.lvl = st.lvl - LVL_W'(1);
        nx.top_obj = below_obj;
        nx.mode = M_CLOSED;
        rr[n[0]] = mk((c == CH_RBRACE) ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 8'd0, nx.lvl,
                      2'd0, 4'd0);
        n = n + 2'd1;
      end
      // primitive start
      if (do_begin) begin
        if (c == 8'h74) nx.lit = LM_T;
        else if (c == 8'h66) nx.lit = LM_F;
        else if (c == 8'h6E) nx.lit = LM_N;
        else if (is_digit(c) || c == CH_PLUS || c == CH_MINUS) nx.lit = LM_NUM;
        else nx.lit = LM_NONE;
        nx.dec = 1'b0;
        nx.mode = M_PRIM;
        rr[n[0]] = mk(EV_PRIM_CHAR, c, st.lvl, 2'd0, 4'd0); n = n + 2'd1;
      end
      // error latch
      if (do_fail) begin
        nx.err = 1'b1;
        rr[n[0]] = mk(EV_ERROR, 8'd0, st.lvl, 2'd0, fcode); n = n + 2'd1;
      end
    end

    // flag the final event of this byte
    if (n == 2'd2) rr[1].last = 1'b1;
    else rr[0].last = 1'b1;

    st_next = nx;
    res0 = rr[0];
    res1 = rr[1];
    nres = n;
  end

endmodule
`default_nettype wire

>>> hdl/jst_outq.sv
// Result queue: takes up to two events per cycle, hands out one per transaction.
`default_nettype none
module jst_outq (
  input  wire  logic                clk,
  input  wire  logic                rst,
  input  wire  logic [1:0]          push_n,
  input  wire  jst_pkg::res_t       push0,
  input  wire  jst_pkg::res_t       push1,
  output logic                      room2,
  output logic                      out_valid,
  input  wire  logic                out_ready,
  output jst_pkg::res_t             head
);
  import jst_pkg::*;

  res_t               q [OQ_DEPTH];
  logic [OQ_AW-1:0]   wptr;
  logic [OQ_AW-1:0]   rptr;
  logic [OQ_AW:0]     cnt;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != '0);
  assign head      = q[rptr];
  assign room2     = (cnt <= (OQ_AW+1)'(OQ_DEPTH - 2));

  // storage writes
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q[wptr] <= push0;
    end
    if (push_n == 2'd2) begin
      q[wptr + OQ_AW'(1)] <= push1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= wptr + OQ_AW'(push_n);
      if (pop) rptr <= rptr + OQ_AW'(1);
      cnt <= cnt + (OQ_AW+1)'(push_n) - (OQ_AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

>>> hdl/json_stream_tokenizer_core.sv
// Top level of the JSON stream tokenizer: state registers, stack RAM, result queue.
//
// Usage:
//   Input channel (in_valid/in_ready/text_byte) takes one byte of JSON text per
//   transaction; a zero byte ends the text and clears the parse state.
//   Output channel (out_valid/out_ready + event fields) delivers the token
//   events, zero to two per byte; last_of_run marks the final one of a byte.
//   cfg_wen/cfg_wdata write depth_limit at any idle clock edge (reset value 32).
//   The events of a byte are registered into the result queue as the byte
//   is accepted. Throughput: one byte per cycle while each byte makes at most
//   one event and the receiver does not stall; the output side moves one
//   event per cycle, so bytes that make two events set the pace to one event
//   per cycle. The per-byte loop has no stall: the container stack RAM is
//   read every cycle at the entry under the top, so a close finds the new top.
//   A four-entry result queue lets input continue while the receiver stalls;
//   in_ready drops only when fewer than two entries are free.
//   Reset (rst, synchronous) clears the parse state and restores depth_limit;
//   the stack RAM is not cleared, entries are written before they are read.
`default_nettype none
module json_stream_tokenizer_core (
  input  wire  logic       clk,
  input  wire  logic       rst,
  input  wire  logic       cfg_wen,
  input  wire  logic [5:0] cfg_wdata,
  input  wire  logic       in_valid,
  output logic             in_ready,
  input  wire  logic [7:0] text_byte,
  output logic             out_valid,
  input  wire  logic       out_ready,
  output logic [3:0]       event_res,
  output logic [7:0]       data_byte,
  output logic [5:0]       nest_depth,
  output logic [1:0]       primitive_kind,
  output logic [3:0]       error_code,
  output logic             last_of_run
);
  import jst_pkg::*;

  pstate_t          st;
  pstate_t          st_step;
  pstate_t          st_next;
  logic [5:0]       depth_limit;
  stk_wr_t          stk_wr;
  res_t             res0, res1, head;
  logic [1:0]       nres;
  logic [1:0]       push_n;
  logic             accept;
  logic             below_obj;
  logic [LVL_W-1:0] below_idx;

  assign accept  = in_valid && in_ready;
  assign st_next = accept ? st_step : st;
  assign push_n  = accept ? nres : 2'd0;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 6'd32;
    end else if (cfg_wen) begin
      depth_limit <= cfg_wdata;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode    <= M_START;
      st.lvl     <= '0;
      st.lit     <= LM_NONE;
      st.dec     <= 1'b0;
      st.err     <= 1'b0;
      st.top_obj <= 1'b0;
    end else begin
      st <= st_next;
    end
  end

  jst_step u_step (
    .st          (st),
    .c           (text_byte),
    .depth_limit (depth_limit),
    .below_obj   (below_obj),
    .st_next     (st_step),
    .stk_wr      (stk_wr),
    .res0        (res0),
    .res1        (res1),
    .nres        (nres)
  );

  // stack RAM: read the entry below next cycle's top every cycle
  assign below_idx = st_next.lvl - LVL_W'(2);

  jst_ram #(
    .WIDTH (1),
    .DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (accept && stk_wr.en),
    .waddr (st.lvl[STK_AW-1:0]),
    .wdata (stk_wr.obj),
    .raddr (below_idx[STK_AW-1:0]),
    .rdata (below_obj)
  );

  jst_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .room2     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign event_res      = head.ev;
  assign data_byte      = head.data;
  assign nest_depth     = head.depth;
  assign primitive_kind = head.kind;
  assign error_code     = head.errc;
  assign last_of_run    = head.last;

endmodule
`default_nettype wire

>>> bench/tokenizer_checker.sv
// Event checker for the JSON stream tokenizer: predicts token events and compares them.
module tokenizer_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic [5:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [3:0] event_res,
  input  logic [7:0] data_byte,
  input  logic [5:0] nest_depth,
  input  logic [1:0] primitive_kind,
  input  logic [3:0] error_code,
  input  logic       last_of_run,
  output int         fails,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import jst_pkg::*;

  // predicted parser state
  logic [5:0] depth_cap;
  mode_t      mode;
  bit         kind_stk [MAX_DEPTH];
  int         levels;
  logic [3:0] lit;
  bit         dot_seen;
  bit         halted;

  // events caused by the byte under prediction
  res_t       byte_ev [2];
  int         n_ev;
  res_t       event_q [$];

  assign pending = event_q.size();

  // next letter expected by the true/false/null matcher
  function automatic logic [7:0] next_letter(input logic [3:0] m);
    case (m)
      LM_T, 4'd11: next_letter = "u";
      4'd3:        next_letter = "u";
      4'd4, 4'd9:  next_letter = "e";
      LM_F:        next_letter = "a";
      4'd7, 4'd12, 4'd13: next_letter = "l";
      4'd8:        next_letter = "s";
      default:     next_letter = 8'h00;
    endcase
    if (m == LM_T) next_letter = "r";
  endfunction

  function automatic bit blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic bit starts_prim(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic bit in_object();
    return levels != 0 && kind_stk[levels-1];
  endfunction

  function automatic int cap_now();
    return depth_cap < MAX_DEPTH ? int'(depth_cap) : MAX_DEPTH;
  endfunction

  task automatic clear_parse();
    mode = M_START;
    levels = 0;
    lit = LM_NONE;
    dot_seen = 0;
    halted = 0;
    foreach (kind_stk[i]) kind_stk[i] = 0;
  endtask

  task automatic post(input logic [3:0] ev, input logic [7:0] d, input logic [1:0] k,
                      input logic [3:0] ec);
    if (n_ev < 2) begin
      byte_ev[n_ev] = '{ev: ev, data: d, depth: levels[5:0], kind: k, errc: ec, last: 1'b0};
      n_ev++;
    end
  endtask

  task automatic abort(input logic [3:0] ec);
    halted = 1;
    post(EV_ERROR, 8'h00, 2'd0, ec);
  endtask

  task automatic push_level(input logic [7:0] c);
    if (levels >= MAX_DEPTH) begin
      abort(ER_DEPTH);
    end else begin
      kind_stk[levels] = (c == CH_LBRACE);
      levels++;
      post(c == CH_LBRACE ? EV_OBJ_OPEN : EV_ARR_OPEN, 8'h00, 2'd0, 4'd0);
      mode = M_ITEM;
    end
  endtask

  task automatic pop_level(input logic [7:0] c);
    if (levels > 0) levels--;
    post(c == CH_RBRACE ? EV_OBJ_CLOSE : EV_ARR_CLOSE, 8'h00, 2'd0, 4'd0);
    mode = M_CLOSED;
  endtask

  task automatic open_prim(input logic [7:0] c);
    if (c == "t") lit = LM_T;
    else if (c == "f") lit = LM_F;
    else if (c == "n") lit = LM_N;
    else if ((c >= "0" && c <= "9") || c == CH_PLUS || c == CH_MINUS) lit = LM_NUM;
    else lit = LM_NONE;
    dot_seen = 0;
    post(EV_PRIM_CHAR, c, 2'd0, 4'd0);
    mode = M_PRIM;
  endtask

  task automatic grow_prim(input logic [7:0] c);
    if (lit == LM_NUM) begin
      if (c == CH_POINT) begin
        if (dot_seen) lit = LM_NONE;
        else dot_seen = 1;
      end else if (c < "0" || c > "9") begin
        lit = LM_NONE;
      end
    end else if (lit != LM_NONE && next_letter(lit) != 8'h00 && next_letter(lit) == c) begin
      lit = lit + 4'd1;
    end else begin
      lit = LM_NONE;
    end
    post(EV_PRIM_CHAR, c, 2'd0, 4'd0);
  endtask

  task automatic top_token(input logic [7:0] c);
    if (levels >= cap_now()) abort(ER_DEPTH);
    else if (c == CH_LBRACE || c == CH_LBRACK) push_level(c);
    else if (c == CH_RBRACE || c == CH_RBRACK || c == CH_QUOTE || starts_prim(c))
      abort(ER_SYNTAX);
    else abort(ER_BADCHAR);
  endtask

  task automatic member_token(input logic [7:0] c);
    bit obj;
    if (levels >= cap_now()) begin
      abort(ER_DEPTH);
      return;
    end
    obj = in_object();
    if (c == CH_LBRACE || c == CH_LBRACK) begin
      if (!obj) push_level(c);
      else abort(c == CH_LBRACE ? ER_OBJ : ER_ARR);
    end else if (c == CH_RBRACE) begin
      if (obj) pop_level(c); else abort(ER_OBJ_END);
    end else if (c == CH_RBRACK) begin
      if (!obj) pop_level(c); else abort(ER_ARR_END);
    end else if (c == CH_QUOTE) begin
      mode = obj ? M_NAME : M_STR;
    end else if (starts_prim(c)) begin
      if (obj) abort(ER_STRING); else open_prim(c);
    end else begin
      abort(ER_BADCHAR);
    end
  endtask

  task automatic value_token(input logic [7:0] c);
    if (c == CH_LBRACE || c == CH_LBRACK) push_level(c);
    else if (c == CH_RBRACE) abort(ER_OBJ_END);
    else if (c == CH_RBRACK) abort(ER_ARR_END);
    else if (c == CH_QUOTE) mode = M_STR;
    else if (starts_prim(c)) open_prim(c);
    else abort(ER_SYNTAX);
  endtask

  task automatic prim_char(input logic [7:0] c);
    if (!(blank(c) || c == CH_COMMA || c == CH_RBRACK || c == CH_RBRACE)) begin
      grow_prim(c);
      return;
    end
    case (lit)
      LM_NUM:   post(EV_PRIM_END, 8'h00, PK_NUM, 4'd0);
      LM_TRUE:  post(EV_PRIM_END, 8'h00, PK_TRUE, 4'd0);
      LM_FALSE: post(EV_PRIM_END, 8'h00, PK_FALSE, 4'd0);
      LM_NULL:  post(EV_PRIM_END, 8'h00, PK_NULL, 4'd0);
      default: begin
        abort(ER_SYNTAX);
        return;
      end
    endcase
    if (blank(c)) mode = M_SEP;
    else if (c == CH_COMMA) mode = M_ITEM;
    else member_token(c);
  endtask

  // work out the events of one accepted byte and queue them
  task automatic predict_byte(input logic [7:0] c);
    n_ev = 0;
    if (c == CH_NUL) begin
      if (!halted) begin
        case (mode)
          M_NAME, M_STR: abort(ER_UNTERM);
          M_COLON, M_VALUE, M_SEP, M_NEED, M_PRIM: abort(ER_EOF);
          default: ;
        endcase
      end
      post(EV_TEXT_END, 8'h00, 2'd0, 4'd0);
      clear_parse();
    end else if (!halted) begin
      case (mode)
        M_START: if (!blank(c)) top_token(c);
        M_ITEM, M_NEED: if (!blank(c)) member_token(c);
        M_NAME: begin
          if (c == CH_QUOTE) begin
            post(EV_NAME_END, 8'h00, 2'd0, 4'd0);
            mode = M_COLON;
          end else if (c == CH_LF) abort(ER_NEWLINE);
          else post(EV_NAME_CHAR, c, 2'd0, 4'd0);
        end
        M_COLON: begin
          if (c == CH_COLON) mode = M_VALUE;
          else if (!blank(c)) abort(ER_SYNTAX);
        end
        M_VALUE: if (!blank(c)) value_token(c);
        M_STR: begin
          if (c == CH_QUOTE) begin
            post(EV_STR_END, 8'h00, 2'd0, 4'd0);
            mode = M_SEP;
          end else if (c == CH_LF) abort(ER_NEWLINE);
          else post(EV_STR_CHAR, c, 2'd0, 4'd0);
        end
        M_PRIM: prim_char(c);
        M_SEP: begin
          if (!blank(c)) begin
            if (c == CH_COMMA) mode = M_ITEM;
            else if (in_object() || c == CH_RBRACK) member_token(c);
            else abort(ER_SYNTAX);
          end
        end
        M_CLOSED: begin
          if (!blank(c)) begin
            if (levels == 0) begin
              if (c == CH_COMMA) abort(ER_COMMA); else top_token(c);
            end else if (c == CH_COMMA) begin
              mode = M_NEED;
            end else begin
              member_token(c);
            end
          end
        end
        default: abort(ER_SYNTAX);
      endcase
    end
    if (n_ev > 0) byte_ev[n_ev-1].last = 1'b1;
    for (int i = 0; i < n_ev; i++) event_q.push_back(byte_ev[i]);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  // watch both channels and the register port
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      depth_cap = 6'd32;
      clear_parse();
      event_q.delete();
    end else begin
      if (cfg_wen) depth_cap = cfg_wdata;
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          report_mismatch("unexpected event", event_res, -1);
        end else begin
          want = event_q.pop_front();
          if (event_res != want.ev) report_mismatch("event_res", event_res, want.ev);
          if (data_byte != want.data) report_mismatch("data_byte", data_byte, want.data);
          if (nest_depth != want.depth) report_mismatch("nest_depth", nest_depth, want.depth);
          if (primitive_kind != want.kind)
            report_mismatch("primitive_kind", primitive_kind, want.kind);
          if (error_code != want.errc) report_mismatch("error_code", error_code, want.errc);
          if (last_of_run != want.last)
            report_mismatch("last_of_run", last_of_run, want.last);
        end
      end
      if (in_valid && in_ready) predict_byte(text_byte);
    end
  end

endmodule

>>> bench/testbench.sv
// Top of the tokenizer bench: clock, reset, JSON text stimulus, receiver and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jst_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_BYTES = 700;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wen;
  logic [5:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] text_byte;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] event_res;
  logic [7:0] data_byte;
  logic [5:0] nest_depth;
  logic [1:0] primitive_kind;
  logic [3:0] error_code;
  logic       last_of_run;
  int         fails;
  int         pending;

  int         bytes_sent = 0;
  bit         calm = 0;
  byte        doc [$];

  json_stream_tokenizer_core dut (
    .clk, .rst, .cfg_wen, .cfg_wdata, .in_valid, .in_ready, .text_byte,
    .out_valid, .out_ready, .event_res, .data_byte, .nest_depth,
    .primitive_kind, .error_code, .last_of_run
  );

  tokenizer_checker chk (
    .clk, .rst, .cfg_wen, .cfg_wdata, .in_valid, .in_ready, .text_byte,
    .out_valid, .out_ready, .event_res, .data_byte, .nest_depth,
    .primitive_kind, .error_code, .last_of_run, .fails, .pending
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    int quiet;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    int hold;
    bit held;
    out_ready <= 1'b0;
    hold = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && bytes_sent >= 300) begin
        held = 1;
        hold = 250;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 22);
      end
    end
  end

  // offer one byte and wait for its transaction
  task automatic send_byte(input byte b);
    if (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(8'h00);
  endtask

  // write depth_limit once all queued events are out
  task automatic set_depth(input logic [5:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic add(input string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
  endtask

  task automatic add_gap();
    if ($urandom_range(3) == 0) add($urandom_range(1) ? " " : "\t");
  endtask

  task automatic add_name_chars(input int quote_content);
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(40) == 0) doc.push_back(CH_LF);
      else if (quote_content) doc.push_back(byte'($urandom_range(8'h23, 8'h7E)));
      else doc.push_back(byte'($urandom_range("a", "z")));
    end
  endtask

  task automatic add_leaf();
    string prims [12] = '{"true", "false", "null", "0", "-12", "+3.5", "7.", "-",
                          "1.2.3", "tru", "nulls", "Zed"};
    if ($urandom_range(2) == 0) begin
      add("\"");
      add_name_chars(1);
      add("\"");
    end else begin
      add(prims[$urandom_range(11)]);
    end
  endtask

  // random JSON text, mostly well formed, with some noise bytes
  task automatic gen_doc();
    bit kinds [$];
    bit obj;
    int r;
    doc.delete();
    obj = $urandom_range(1);
    add(obj ? "{" : "[");
    kinds.push_back(obj);
    repeat ($urandom_range(2, 14)) begin
      if (kinds.size() == 0) break;
      r = $urandom_range(99);
      obj = kinds[$];
      add_gap();
      if (r < 4) begin
        doc.push_back(byte'($urandom_range(1, 255)));
      end else if (r < 22 && kinds.size() < 7) begin
        if (obj) begin
          add("\"");
          add_name_chars(0);
          add("\":");
        end
        r = $urandom_range(1);
        add(r ? "{" : "[");
        kinds.push_back(r);
      end else if (r < 38) begin
        add(obj ? "}" : "]");
        void'(kinds.pop_back());
        if (kinds.size() != 0 && (!kinds[$] || $urandom_range(1))) add(",");
      end else begin
        if (obj) begin
          add("\"");
          add_name_chars(0);
          add("\"");
          add_gap();
          add(":");
          add_gap();
        end
        add_leaf();
        if (!obj || $urandom_range(1)) add(",");
        else add($urandom_range(1) ? " " : "\r");
      end
    end
    if ($urandom_range(9) != 0)
      while (kinds.size() != 0) add(kinds.pop_back() ? "}" : "]");
    if ($urandom_range(7) == 0) add(" []");
    doc.push_back(8'h00);
  endtask

  task automatic random_texts(input int count);
    int stop;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      gen_doc();
      foreach (doc[i]) send_byte(doc[i]);
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_wdata <= 6'd0;
    in_valid <= 1'b0;
    text_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed texts under the reset limit
    send_text("{\"ab\":true,\"c\":[false,null]}");
    send_text("[1,-2.5,+,\"s\"]");
    send_text("[1.2.3]");
    send_text("[tru]");
    send_text("[\"a\nb\"]");
    send_text("{\"k\"");
    send_text("[7");
    send_text("\"x\"");
    send_text("#");
    send_text("[],");
    send_text("{[");
    send_text("[}");
    send_text("{\"k\":]");
    send_text("[[],[1,],]");
    send_byte(8'hFF);
    send_byte(8'h00);

    // limit zero, one, and out of range
    set_depth(6'd0);
    send_text("[1]");
    set_depth(6'd1);
    send_text("[[");
    send_text("{\"a\":1}");
    set_depth(6'd63);
    send_text("[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[[");
    random_texts(100);
    set_depth(6'd32);
    random_texts(100);
    set_depth(6'($urandom_range(2, 5)));
    random_texts(100);
    calm = 1;
    set_depth(6'd3);
    random_texts(70);
    calm = 0;
    set_depth(6'($urandom_range(0, 63)));
    random_texts(100);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/jst_pkg.sv
hdl/jst_ram.sv
hdl/jst_step.sv
hdl/jst_outq.sv
hdl/json_stream_tokenizer_core.sv
bench/tokenizer_checker.sv
bench/testbench.sv
